### hw/rtl/ufp_pkg.sv
package ufp_pkg;

    localparam logic [15:0] MAGIC_WORD   = 16'h02AA;
    localparam logic [16:0] HEADER_BYTES = 17'd5;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_USER     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_NO_ROOM  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BLOCK  = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    // byte index within a block header while in PH_BLOCK
    localparam logic [8:0] BLK_SCORE_HI = 9'd0;
    localparam logic [8:0] BLK_SCORE_LO = 9'd1;

    // header byte positions
    localparam logic [15:0] HDR_MAGIC_HI = 16'd0;
    localparam logic [15:0] HDR_MAGIC_LO = 16'd1;
    localparam logic [15:0] HDR_LEN_HI   = 16'd2;
    localparam logic [15:0] HDR_LEN_LO   = 16'd3;

endpackage

### hw/rtl/user_frame_parser_top.sv
// Channel  | Ports                                                  | Direction
// ---------+--------------------------------------------------------+----------
// input    | s_valid s_ready s_data_byte s_frame_start s_buffer_len | in
// result   | m_valid m_ready m_kind m_score m_name_size             | out
//          | m_name_offset m_record_index m_last                    |
// config   | cfg_wr_en cfg_wr_data (max_users)                      | in
//
// One byte per cycle sustained unless the result side stalls: a beat is held
// in the input register, then the parser updates its state and loads the
// result register; m_valid rises if that beat yields a result.
// A stalled result register holds a full input register and so s_ready low.
// aresetn is synchronous, active low; it idles the parser and sets max_users
// to 255.
module user_frame_parser_top
    import ufp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_start,
    input  logic [15:0] s_buffer_len,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_score,
    output logic [7:0]  m_name_size,
    output logic [15:0] m_name_offset,
    output logic [7:0]  m_record_index,
    output logic        m_last
);

    // config
    logic [7:0]  max_users_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [15:0] in_blen_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] byte_pos_reg, byte_pos_next;
    logic [15:0] magic_hold_reg, magic_hold_next;
    logic [15:0] payload_len_reg, payload_len_next;
    logic [7:0]  block_total_reg, block_total_next;
    logic [7:0]  blocks_done_reg, blocks_done_next;
    logic [15:0] score_hold_reg, score_hold_next;
    logic [8:0]  skip_count_reg, skip_count_next;

    // result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [15:0] out_score_reg;
    logic [7:0]  out_name_size_reg;
    logic [15:0] out_name_off_reg;
    logic [7:0]  out_index_reg;
    logic        out_last_reg;

    // result of the current beat
    logic        res_valid;
    kind_t       res_kind;
    logic [15:0] res_score;
    logic [7:0]  res_name_size;
    logic [15:0] res_name_off;
    logic [7:0]  res_index;
    logic        res_last;

    logic        advance;
    logic        fire;
    phase_t      ph_cur;
    logic [15:0] cur;
    logic [16:0] name_at;
    logic [17:0] next_block;
    logic [16:0] payload_end;
    logic        blk_last;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign ph_cur      = in_start_reg ? PH_HEADER : phase_reg;
    assign cur         = in_start_reg ? 16'd0 : byte_pos_reg;
    assign name_at     = {1'b0, cur} + 17'd1;
    assign next_block  = {1'b0, name_at} + {10'd0, in_byte_reg} + 18'd1;
    assign payload_end = {1'b0, payload_len_reg} + HEADER_BYTES;
    assign blk_last    = ({1'b0, blocks_done_reg} + 9'd1 >= {1'b0, block_total_reg})
                      || (next_block >= {1'b0, payload_end})
                      || (cur == POS_MAX);

    always_comb begin
        phase_next       = ph_cur;
        byte_pos_next    = (cur == POS_MAX) ? cur : cur + 16'd1;
        magic_hold_next  = magic_hold_reg;
        payload_len_next = payload_len_reg;
        block_total_next = block_total_reg;
        blocks_done_next = blocks_done_reg;
        score_hold_next  = score_hold_reg;
        skip_count_next  = skip_count_reg;
        res_valid        = 1'b0;
        res_kind         = KIND_USER;
        res_score        = '0;
        res_name_size    = '0;
        res_name_off     = '0;
        res_index        = '0;
        res_last         = 1'b0;

        unique case (ph_cur)
            PH_IDLE: begin
                // drop stray bytes outside a frame
                byte_pos_next = byte_pos_reg;
            end
            PH_HEADER: begin
                priority if (cur == HDR_MAGIC_HI) begin
                    magic_hold_next = {in_byte_reg, 8'd0};
                end else if (cur == HDR_MAGIC_LO) begin
                    magic_hold_next = {magic_hold_reg[15:8], in_byte_reg};
                end else if (cur == HDR_LEN_HI) begin
                    payload_len_next = {in_byte_reg, 8'd0};
                end else if (cur == HDR_LEN_LO) begin
                    payload_len_next = {payload_len_reg[15:8], in_byte_reg};
                end else begin
                    block_total_next = in_byte_reg;
                    blocks_done_next = '0;
                    skip_count_next  = '0;
                    priority if (magic_hold_reg != MAGIC_WORD) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_BAD_MAGIC;
                    end else if (in_byte_reg == 8'd0 || payload_len_reg == 16'd0) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_EMPTY;
                    end else if (in_byte_reg > max_users_reg
                                 || payload_end > {1'b0, in_blen_reg}) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_NO_ROOM;
                    end else begin
                        phase_next = PH_BLOCK;
                    end
                    if (res_valid) begin
                        res_last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_BLOCK: begin
                priority if (skip_count_reg == BLK_SCORE_HI) begin
                    score_hold_next = {in_byte_reg, 8'd0};
                    skip_count_next = BLK_SCORE_LO;
                end else if (skip_count_reg == BLK_SCORE_LO) begin
                    score_hold_next = {score_hold_reg[15:8], in_byte_reg};
                    skip_count_next = skip_count_reg + 9'd1;
                end else begin
                    res_valid        = 1'b1;
                    res_kind         = KIND_USER;
                    res_score        = score_hold_reg;
                    res_name_size    = in_byte_reg;
                    res_name_off     = name_at[16] ? POS_MAX : name_at[15:0];
                    res_index        = blocks_done_reg;
                    res_last         = blk_last;
                    blocks_done_next = blocks_done_reg + 8'd1;
                    if (blk_last) begin
                        phase_next      = PH_IDLE;
                        skip_count_next = '0;
                    end else begin
                        // name bytes plus the null byte
                        skip_count_next = {1'b0, in_byte_reg} + 9'd1;
                        phase_next      = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                skip_count_next = skip_count_reg - 9'd1;
                if (skip_count_reg == 9'd1) begin
                    phase_next = PH_BLOCK;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_users_reg <= 8'd255;
        end else if (cfg_wr_en) begin
            max_users_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_frame_start;
            in_blen_reg  <= s_buffer_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            byte_pos_reg    <= '0;
            magic_hold_reg  <= '0;
            payload_len_reg <= '0;
            block_total_reg <= '0;
            blocks_done_reg <= '0;
            score_hold_reg  <= '0;
            skip_count_reg  <= '0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            magic_hold_reg  <= magic_hold_next;
            payload_len_reg <= payload_len_next;
            block_total_reg <= block_total_next;
            blocks_done_reg <= blocks_done_next;
            score_hold_reg  <= score_hold_next;
            skip_count_reg  <= skip_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_kind_reg      <= res_kind;
            out_score_reg     <= res_score;
            out_name_size_reg <= res_name_size;
            out_name_off_reg  <= res_name_off;
            out_index_reg     <= res_index;
            out_last_reg      <= res_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_score        = out_score_reg;
    assign m_name_size    = out_name_size_reg;
    assign m_name_offset  = out_name_off_reg;
    assign m_record_index = out_index_reg;
    assign m_last         = out_last_reg;

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_USER |-> out_last_reg && out_score_reg == 16'd0)
        else $error("status result without last or with nonzero score");

    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && res_last |=> phase_reg == PH_IDLE)
        else $error("parser not idle after frame end");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_count_reg != 9'd0)
        else $error("skip phase with zero count");

    a_blocks_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BLOCK || phase_reg == PH_SKIP |-> blocks_done_reg < block_total_reg)
        else $error("blocks done reached block total inside a frame");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import ufp_pkg::*;
();

    typedef struct packed {
        kind_t       kind;
        logic [15:0] score;
        logic [7:0]  name_size;
        logic [15:0] name_offset;
        logic [7:0]  record_index;
        logic        last;
    } user_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_start = 1'b0;
    logic [15:0] s_buffer_len = 16'h0000;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_score;
    logic [7:0]  m_name_size;
    logic [15:0] m_name_offset;
    logic [7:0]  m_record_index;
    logic        m_last;

    user_frame_parser_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_start  (s_frame_start),
        .s_buffer_len   (s_buffer_len),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_score        (m_score),
        .m_name_size    (m_name_size),
        .m_name_offset  (m_name_offset),
        .m_record_index (m_record_index),
        .m_last         (m_last)
    );

    always #1 aclk = ~aclk;

    user_rec_t   expected_records[$];
    logic [7:0]  frame_bytes[$];
    int          fail_count = 0;
    int          beats_sent = 0;
    int          tx_idle_pct = 20;
    int          rx_idle_pct = 20;
    int          hold_req = 0;
    int          stall_left = 0;

    // parser state as predicted from the accepted beats
    phase_t      ph = PH_IDLE;
    logic [15:0] pos = '0;
    logic [15:0] magic_acc = '0;
    logic [15:0] pay_len = '0;
    logic [7:0]  blk_total = '0;
    logic [7:0]  blk_done = '0;
    logic [15:0] score_acc = '0;
    logic [8:0]  blk_byte = '0;
    logic [7:0]  max_users_model = 8'd255;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void frame_refused(kind_t k);
        user_rec_t rec;
        rec = '0;
        rec.kind = k;
        rec.last = 1'b1;
        expected_records.push_back(rec);
        ph = PH_IDLE;
    endfunction

    function automatic void parse_byte(logic [7:0] d, logic st, logic [15:0] bl);
        logic [15:0] cur;
        int          name_at;
        int          next_blk;
        int          pay_end;
        logic        ends;
        user_rec_t   rec;
        if (st) begin
            ph = PH_HEADER;
            pos = '0;
        end else if (ph == PH_IDLE) begin
            return;
        end
        cur = pos;
        if (pos != POS_MAX) pos = pos + 16'd1;
        case (ph)
            PH_HEADER: begin
                case (cur)
                    HDR_MAGIC_HI: magic_acc = {d, 8'h00};
                    HDR_MAGIC_LO: magic_acc[7:0] = d;
                    HDR_LEN_HI:   pay_len = {d, 8'h00};
                    HDR_LEN_LO:   pay_len[7:0] = d;
                    default: begin
                        blk_total = d;
                        blk_done = '0;
                        blk_byte = '0;
                        if (magic_acc != MAGIC_WORD)
                            frame_refused(KIND_BAD_MAGIC);
                        else if (d == 8'd0 || pay_len == 16'd0)
                            frame_refused(KIND_EMPTY);
                        else if (d > max_users_model ||
                                 int'(pay_len) + int'(HEADER_BYTES) > int'(bl))
                            frame_refused(KIND_NO_ROOM);
                        else
                            ph = PH_BLOCK;
                    end
                endcase
            end
            PH_BLOCK: begin
                if (blk_byte == BLK_SCORE_HI) begin
                    score_acc = {d, 8'h00};
                    blk_byte = BLK_SCORE_LO;
                end else if (blk_byte == BLK_SCORE_LO) begin
                    score_acc[7:0] = d;
                    blk_byte = BLK_SCORE_LO + 9'd1;
                end else begin
                    // name-length byte: emit the record, then skip name and null
                    name_at = int'(cur) + 1;
                    next_blk = name_at + int'(d) + 1;
                    pay_end = int'(pay_len) + int'(HEADER_BYTES);
                    ends = (int'(blk_done) + 1 >= int'(blk_total)) ||
                           (next_blk >= pay_end) || (cur == POS_MAX);
                    rec = '0;
                    rec.kind = KIND_USER;
                    rec.score = score_acc;
                    rec.name_size = d;
                    rec.name_offset = (name_at > 65535) ? POS_MAX : name_at[15:0];
                    rec.record_index = blk_done;
                    rec.last = ends;
                    expected_records.push_back(rec);
                    blk_done = blk_done + 8'd1;
                    if (ends) begin
                        ph = PH_IDLE;
                        blk_byte = '0;
                    end else begin
                        blk_byte = {1'b0, d} + 9'd1;
                        ph = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (blk_byte != 9'd0) blk_byte = blk_byte - 9'd1;
                if (blk_byte == 9'd0) ph = PH_BLOCK;
            end
            default: ph = PH_IDLE;
        endcase
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        user_rec_t rec;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $error("result beat with none pending: kind %0d", m_kind);
                fail_count++;
            end else begin
                rec = expected_records.pop_front();
                check_field("kind", rec.kind, m_kind);
                check_field("score", rec.score, m_score);
                check_field("name_size", rec.name_size, m_name_size);
                check_field("name_offset", rec.name_offset, m_name_offset);
                check_field("record_index", rec.record_index, m_record_index);
                check_field("last", rec.last, m_last);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req <= 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic st, input logic [15:0] bl);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct) gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_frame_start <= st;
        s_buffer_len <= bl;
        do @(posedge aclk); while (!s_ready);
        parse_byte(d, st, bl);
        beats_sent++;
    endtask

    // buffer_len only matters on the fifth header byte; randomize it elsewhere
    task automatic send_frame(input logic [15:0] blen);
        foreach (frame_bytes[i])
            send_beat(frame_bytes[i], i == 0, (i == 4) ? blen : 16'($urandom));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            guard++;
        end while (expected_records.size() != 0 && guard < 5000);
        if (expected_records.size() != 0) begin
            $error("%0d results never arrived", expected_records.size());
            fail_count++;
            expected_records.delete();
        end
        // let a beat without a result clear the pipeline
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_max_users(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        max_users_model = v;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic put_header(input logic [15:0] magic, input logic [15:0] plen,
                              input logic [7:0] cnt);
        frame_bytes.delete();
        frame_bytes.push_back(magic[15:8]);
        frame_bytes.push_back(magic[7:0]);
        frame_bytes.push_back(plen[15:8]);
        frame_bytes.push_back(plen[7:0]);
        frame_bytes.push_back(cnt);
    endtask

    task automatic put_block(input logic [15:0] score, input logic [7:0] nl);
        frame_bytes.push_back(score[15:8]);
        frame_bytes.push_back(score[7:0]);
        frame_bytes.push_back(nl);
        repeat (nl) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'h00);
    endtask

    task automatic make_frame(output logic [15:0] blen);
        int          nblk;
        int          nl;
        int          cnt;
        int          plen;
        int          body;
        int          sel;
        logic [15:0] magic;
        nblk = $urandom_range(1, 5);
        sel = $urandom_range(0, 99);
        cnt = nblk;
        if (sel < 10) cnt = nblk + $urandom_range(1, 3);
        else if (sel < 16) cnt = $urandom_range(0, 255);
        else if (sel < 22) cnt = max_users_model + $urandom_range(0, 1);
        if (cnt > 255) cnt = 255;
        magic = MAGIC_WORD;
        sel = $urandom_range(0, 99);
        if (sel < 6) magic = magic ^ (16'd1 << $urandom_range(0, 15));
        else if (sel < 8) magic = 16'($urandom);
        put_header(magic, 16'd0, 8'(cnt));
        for (int i = 0; i < nblk; i++) begin
            nl = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            put_block(16'($urandom), 8'(nl));
            if ($urandom_range(0, 9) == 0) frame_bytes[frame_bytes.size() - 1] = 8'($urandom);
        end
        body = frame_bytes.size() - 5;
        sel = $urandom_range(0, 99);
        plen = body;
        if (sel < 12) plen = $urandom_range(1, body);
        else if (sel < 24) plen = body + $urandom_range(1, 20);
        else if (sel < 26) plen = 0;
        frame_bytes[2] = 8'(plen >> 8);
        frame_bytes[3] = 8'(plen);
        if ($urandom_range(0, 99) < 85) begin
            blen = (plen + 5 + 40 > 65535) ? 16'hFFFF : 16'(plen + 5 + $urandom_range(0, 40));
        end else begin
            blen = 16'(plen + 5 - $urandom_range(1, 3));
        end
        // cut some frames short; the next frame start restarts the parser
        if ($urandom_range(0, 99) < 8) begin
            sel = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > sel) void'(frame_bytes.pop_back());
        end
    endtask

    task automatic test_header_checks();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        put_header(~MAGIC_WORD, 16'd4, 8'd1);
        send_frame(16'hFFFF);
        put_header(MAGIC_WORD, 16'd0, 8'd3);
        send_frame(16'hFFFF);
        put_header(MAGIC_WORD, 16'd10, 8'd0);
        send_frame(16'hFFFF);
        // payload length plus header overflows 16 bits
        put_header(MAGIC_WORD, 16'hFFFB, 8'd1);
        send_frame(16'hFFFF);
        put_header(MAGIC_WORD, 16'd4, 8'd1);
        send_frame(16'd8);
        put_block(16'hFFFF, 8'd0);
        send_frame(16'd9);
        wait_drained();
    endtask

    task automatic test_framing();
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        // stray beats while idle
        send_beat(8'hFF, 1'b0, 16'hFFFF);
        send_beat(8'h00, 1'b0, 16'h0000);
        // restart inside the header
        put_header(MAGIC_WORD, 16'd9, 8'd2);
        for (int i = 0; i < 3; i++) send_beat(frame_bytes[i], i == 0, 16'hFFFF);
        put_block(16'hFFFF, 8'd0);
        put_block(16'h0000, 8'd1);
        send_frame(16'd14);
        // beats after the frame end are dropped
        send_beat(8'h02, 1'b0, 16'hFFFF);
        send_beat(8'hAA, 1'b0, 16'hFFFF);
        // restart inside a name
        put_header(MAGIC_WORD, 16'd20, 8'd3);
        put_block(16'h8001, 8'd6);
        for (int i = 0; i < 10; i++) send_beat(frame_bytes[i], i == 0, 16'd25);
        put_header(MAGIC_WORD, 16'd4, 8'd5);
        put_block(16'h7FFE, 8'd0);
        send_frame(16'd9);
        wait_drained();
    endtask

    task automatic test_limits();
        logic [7:0] lim[5];
        lim[0] = 8'd0;
        lim[1] = 8'd1;
        lim[2] = 8'd254;
        lim[3] = 8'($urandom_range(2, 253));
        lim[4] = 8'd255;
        foreach (lim[k]) begin
            set_max_users(lim[k]);
            put_header(MAGIC_WORD, 16'd4, lim[k]);
            put_block(16'($urandom), 8'd0);
            send_frame(16'd9);
            if (lim[k] != 8'd255) begin
                put_header(MAGIC_WORD, 16'd4, lim[k] + 8'd1);
                put_block(16'($urandom), 8'd0);
                send_frame(16'd9);
            end
            // empty wins over no room, bad magic over both
            put_header(MAGIC_WORD, 16'd0, 8'd255);
            send_frame(16'd0);
            put_header(16'h0000, 16'd0, 8'd255);
            send_frame(16'd0);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 200;
        repeat (4) begin
            put_header(MAGIC_WORD, 16'd0, 8'd6);
            repeat (6) put_block(16'($urandom), 8'($urandom_range(0, 2)));
            frame_bytes[2] = 8'((frame_bytes.size() - 5) >> 8);
            frame_bytes[3] = 8'(frame_bytes.size() - 5);
            send_frame(16'hFFFF);
        end
        wait_drained();
    endtask

    task automatic test_random();
        logic [15:0] blen;
        int          goal;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: set_max_users(8'd255);
                1: set_max_users(8'($urandom_range(5, 254)));
                default: set_max_users(8'($urandom_range(1, 4)));
            endcase
            goal = beats_sent + 260;
            while (beats_sent < goal) begin
                if ($urandom_range(0, 4) == 0) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end else begin
                    tx_idle_pct = $urandom_range(10, 50);
                    rx_idle_pct = $urandom_range(10, 50);
                end
                make_frame(blen);
                send_frame(blen);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_beat(8'($urandom), 1'b0, 16'($urandom));
                if ($urandom_range(0, 24) == 0) wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_header_checks();
        test_framing();
        test_limits();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ufp_pkg.sv
hw/rtl/user_frame_parser_top.sv
dv/testbench.sv
